// ===== src/rc4_stream_cipher_defines.svh =====
// Assertion macros shared by the RC4 stream cipher RTL
`ifndef RC4_STREAM_CIPHER_DEFINES_SVH
`define RC4_STREAM_CIPHER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge outside reset
`define RC4_ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Trigger in one cycle implies a consequence in the next
`define RC4_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`else

`define RC4_ASSERT_HOLDS(lbl, clk, rst_n, prop, msg)

`define RC4_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)

`endif

`endif

// ===== src/rc4_pkg.sv =====
// Shared types and constants of the RC4 stream cipher
package rc4_pkg;

    localparam int DEFAULT_MAX_KEY_BYTES = 32;
    localparam int SBOX_DEPTH            = 256;
    localparam int BYTE_W                = 8;
    localparam int KEY_WORDS             = 4;
    localparam int CFG_DATA_W            = 64;
    localparam int CFG_ADDR_W            = 3;
    localparam int LEN_W                 = 6;

    localparam logic [LEN_W-1:0] KEY_LENGTH_RESET = LEN_W'(16);

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_WORD_0 = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_WORD_1 = CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_WORD_2 = CFG_ADDR_W'(2);
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_WORD_3 = CFG_ADDR_W'(3);
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_LENGTH = CFG_ADDR_W'(4);

    // Request types
    localparam logic REQ_KEY_SCHEDULE = 1'b0;
    localparam logic REQ_DATA         = 1'b1;

    // Datapath step selected by the controller
    typedef enum logic [3:0] {
        STEP_NONE,
        STEP_INIT,
        STEP_KS_RD_K,
        STEP_KS_RD_ACC,
        STEP_KS_WR_K,
        STEP_KS_WR_ACC,
        STEP_BY_RD_I,
        STEP_BY_RD_J,
        STEP_BY_WR_I,
        STEP_BY_WR_J,
        STEP_OUT
    } t_step;

    typedef struct packed {
        logic  accept;
        t_step step;
    } t_dp_cmd;

    typedef struct packed {
        logic keyed;
        logic k_last;
        logic out_free;
    } t_dp_status;

endpackage

// ===== src/rc4_req_if.sv =====
// Request channel: valid/ready handshake with request payload
interface rc4_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] data_byte;
    logic       end_of_message;

    modport source (output valid, output req_type, output data_byte,
                    output end_of_message, input ready);
    modport sink   (input valid, input req_type, input data_byte,
                    input end_of_message, output ready);
endinterface

// ===== src/rc4_rsp_if.sv =====
// Result channel: valid/ready handshake with result payload
interface rc4_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       end_of_message_out;
    logic       not_keyed;

    modport source (output valid, output out_byte, output end_of_message_out,
                    output not_keyed, input ready);
    modport sink   (input valid, input out_byte, input end_of_message_out,
                    input not_keyed, output ready);
endinterface

// ===== src/rc4_ctrl.sv =====
// Sequencing state machine of the RC4 stream cipher
`include "rc4_stream_cipher_defines.svh"

module rc4_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_req_type,
    output logic                o_in_ready,
    input  rc4_pkg::t_dp_status i_status,
    output rc4_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_KS_RD_K,
        ST_KS_RD_ACC,
        ST_KS_WR_K,
        ST_KS_WR_ACC,
        ST_BY_RD_I,
        ST_BY_RD_J,
        ST_BY_WR_I,
        ST_BY_WR_J,
        ST_BY_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_req_type == rc4_pkg::REQ_KEY_SCHEDULE) begin
                        n_state = ST_INIT;
                    end else if (i_status.keyed) begin
                        n_state = ST_BY_RD_I;
                    end else begin
                        n_state = ST_BY_OUT;
                    end
                end
            end
            ST_INIT: begin
                if (i_status.k_last) begin
                    n_state = ST_KS_RD_K;
                end
            end
            ST_KS_RD_K:   n_state = ST_KS_RD_ACC;
            ST_KS_RD_ACC: n_state = ST_KS_WR_K;
            ST_KS_WR_K:   n_state = ST_KS_WR_ACC;
            ST_KS_WR_ACC: begin
                n_state = i_status.k_last ? ST_IDLE : ST_KS_RD_K;
            end
            ST_BY_RD_I: n_state = ST_BY_RD_J;
            ST_BY_RD_J: n_state = ST_BY_WR_I;
            ST_BY_WR_I: n_state = ST_BY_WR_J;
            ST_BY_WR_J: n_state = ST_BY_OUT;
            ST_BY_OUT: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd.accept = w_accept;
        case (r_state)
            ST_INIT:      o_cmd.step = rc4_pkg::STEP_INIT;
            ST_KS_RD_K:   o_cmd.step = rc4_pkg::STEP_KS_RD_K;
            ST_KS_RD_ACC: o_cmd.step = rc4_pkg::STEP_KS_RD_ACC;
            ST_KS_WR_K:   o_cmd.step = rc4_pkg::STEP_KS_WR_K;
            ST_KS_WR_ACC: o_cmd.step = rc4_pkg::STEP_KS_WR_ACC;
            ST_BY_RD_I:   o_cmd.step = rc4_pkg::STEP_BY_RD_I;
            ST_BY_RD_J:   o_cmd.step = rc4_pkg::STEP_BY_RD_J;
            ST_BY_WR_I:   o_cmd.step = rc4_pkg::STEP_BY_WR_I;
            ST_BY_WR_J:   o_cmd.step = rc4_pkg::STEP_BY_WR_J;
            ST_BY_OUT:    o_cmd.step = rc4_pkg::STEP_OUT;
            default:      o_cmd.step = rc4_pkg::STEP_NONE;
        endcase
    end

    `RC4_ASSERT_NEXT(a_key_req_starts_init, i_clk, i_rst_n, w_accept && (i_req_type == rc4_pkg::REQ_KEY_SCHEDULE), r_state == ST_INIT, "key request did not start the fill")
    `RC4_ASSERT_NEXT(a_out_waits_for_slot, i_clk, i_rst_n, (r_state == ST_BY_OUT) && !i_status.out_free, r_state == ST_BY_OUT, "left output step while slot busy")
    `RC4_ASSERT_NEXT(a_schedule_ends_idle, i_clk, i_rst_n, (r_state == ST_KS_WR_ACC) && i_status.k_last, r_state == ST_IDLE, "key schedule did not end after last swap")

endmodule

// ===== src/rc4_dp.sv =====
// Datapath of the RC4 stream cipher: key registers, S-box memory, indices
`include "rc4_stream_cipher_defines.svh"

module rc4_dp #(
    parameter int MAX_KEY_BYTES = rc4_pkg::DEFAULT_MAX_KEY_BYTES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rc4_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [rc4_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  rc4_pkg::t_dp_cmd                    i_cmd,
    output rc4_pkg::t_dp_status                 o_status,
    input  logic [rc4_pkg::BYTE_W-1:0]          i_data_byte,
    input  logic                                i_end_of_message,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [rc4_pkg::BYTE_W-1:0]          o_out_byte,
    output logic                                o_end_of_message_out,
    output logic                                o_not_keyed
);

    localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam logic [rc4_pkg::LEN_W-1:0] MAX_LEN = rc4_pkg::LEN_W'(MAX_KEY_BYTES);
    localparam int BW = rc4_pkg::BYTE_W;

    // Key registers
    logic [rc4_pkg::CFG_DATA_W-1:0] r_key_word [rc4_pkg::KEY_WORDS];
    logic [rc4_pkg::LEN_W-1:0]      r_key_length;
    logic [BW-1:0]                  w_key_bytes [MAX_KEY_BYTES];
    logic [rc4_pkg::LEN_W-1:0]      w_len_eff;
    logic [rc4_pkg::LEN_W-1:0]      w_len_m1;
    logic [KIDX_W-1:0]              w_last_kidx;

    // Cipher state
    logic [BW-1:0]     r_sbox [rc4_pkg::SBOX_DEPTH];
    logic [BW-1:0]     r_rd;
    logic [BW-1:0]     r_k;
    logic [KIDX_W-1:0] r_kidx;
    logic [BW-1:0]     r_acc;
    logic [BW-1:0]     r_i;
    logic [BW-1:0]     r_j;
    logic              r_keyed;
    logic [BW-1:0]     r_sk;
    logic [BW-1:0]     r_sj;
    logic              r_fwd_i;
    logic              r_fwd_j;
    logic [BW-1:0]     r_data;
    logic              r_eom;

    // Output register
    logic          r_out_valid;
    logic [BW-1:0] r_out_byte;
    logic          r_out_eom;
    logic          r_out_nk;

    // Memory port
    logic          w_wr_en;
    logic [BW-1:0] w_wr_addr;
    logic [BW-1:0] w_wr_data;
    logic          w_rd_en;
    logic [BW-1:0] w_rd_addr;

    logic [BW-1:0] w_acc_n;
    logic [BW-1:0] w_i_n;
    logic [BW-1:0] w_j_n;
    logic [BW-1:0] w_t;
    logic [BW-1:0] w_ks;
    logic          w_out_free;
    logic          w_load_out;

    genvar g;
    generate
        for (g = 0; g < MAX_KEY_BYTES; g++) begin : g_key_bytes
            assign w_key_bytes[g] = r_key_word[g / 8][(g % 8) * BW +: BW];
        end
    endgenerate

    always_comb begin
        w_len_eff = r_key_length;
        if (r_key_length == '0) begin
            w_len_eff = rc4_pkg::LEN_W'(1);
        end else if (r_key_length > MAX_LEN) begin
            w_len_eff = MAX_LEN;
        end
    end

    assign w_len_m1    = w_len_eff - rc4_pkg::LEN_W'(1);
    assign w_last_kidx = w_len_m1[KIDX_W-1:0];

    assign w_acc_n = r_acc + r_rd + w_key_bytes[r_kidx];
    assign w_i_n   = r_i + BW'(1);
    assign w_j_n   = r_j + r_rd;
    assign w_t     = r_sk + r_rd;

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_k;
        w_wr_data = r_k;
        w_rd_en   = 1'b0;
        w_rd_addr = r_k;
        case (i_cmd.step)
            rc4_pkg::STEP_INIT: begin
                w_wr_en = 1'b1;
            end
            rc4_pkg::STEP_KS_RD_K: begin
                w_rd_en = 1'b1;
            end
            rc4_pkg::STEP_KS_RD_ACC: begin
                w_rd_en   = 1'b1;
                w_rd_addr = w_acc_n;
            end
            rc4_pkg::STEP_KS_WR_K: begin
                w_wr_en   = 1'b1;
                w_wr_data = r_rd;
            end
            rc4_pkg::STEP_KS_WR_ACC: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_acc;
                w_wr_data = r_sk;
            end
            rc4_pkg::STEP_BY_RD_I: begin
                w_rd_en   = 1'b1;
                w_rd_addr = w_i_n;
            end
            rc4_pkg::STEP_BY_RD_J: begin
                w_rd_en   = 1'b1;
                w_rd_addr = w_j_n;
            end
            rc4_pkg::STEP_BY_WR_I: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_i;
                w_wr_data = r_rd;
                w_rd_en   = 1'b1;
                w_rd_addr = w_t;
            end
            rc4_pkg::STEP_BY_WR_J: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_j;
                w_wr_data = r_sk;
            end
            default: begin
                w_wr_en = 1'b0;
            end
        endcase
    end

    // S-box: one write port, one registered read port (old data on collision)
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_sbox[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd <= r_sbox[w_rd_addr];
        end
    end

    // Keystream byte: the read was issued while S[i] was being rewritten
    // and before S[j] was, so take the swapped values where they collide
    always_comb begin
        if (!r_keyed) begin
            w_ks = '0;
        end else if (r_fwd_i) begin
            w_ks = r_sj;
        end else if (r_fwd_j) begin
            w_ks = r_sk;
        end else begin
            w_ks = r_rd;
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_load_out = (i_cmd.step == rc4_pkg::STEP_OUT) && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_word[0] <= '0;
            r_key_word[1] <= '0;
            r_key_word[2] <= '0;
            r_key_word[3] <= '0;
            r_key_length  <= rc4_pkg::KEY_LENGTH_RESET;
            r_k           <= '0;
            r_kidx        <= '0;
            r_acc         <= '0;
            r_i           <= '0;
            r_j           <= '0;
            r_keyed       <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    rc4_pkg::CFG_KEY_WORD_0: r_key_word[0] <= i_cfg_wdata;
                    rc4_pkg::CFG_KEY_WORD_1: r_key_word[1] <= i_cfg_wdata;
                    rc4_pkg::CFG_KEY_WORD_2: r_key_word[2] <= i_cfg_wdata;
                    rc4_pkg::CFG_KEY_WORD_3: r_key_word[3] <= i_cfg_wdata;
                    rc4_pkg::CFG_KEY_LENGTH: begin
                        r_key_length <= i_cfg_wdata[rc4_pkg::LEN_W-1:0];
                    end
                    default: begin
                        r_key_length <= r_key_length;
                    end
                endcase
            end

            if (i_cmd.accept) begin
                r_k    <= '0;
                r_kidx <= '0;
                r_acc  <= '0;
            end

            case (i_cmd.step)
                rc4_pkg::STEP_INIT: begin
                    r_k <= r_k + BW'(1);
                end
                rc4_pkg::STEP_KS_RD_ACC: begin
                    r_acc  <= w_acc_n;
                    r_kidx <= (r_kidx == w_last_kidx) ? '0 : r_kidx + KIDX_W'(1);
                end
                rc4_pkg::STEP_KS_WR_ACC: begin
                    r_k <= r_k + BW'(1);
                    if (r_k == '1) begin
                        r_keyed <= 1'b1;
                        r_i     <= '0;
                        r_j     <= '0;
                    end
                end
                rc4_pkg::STEP_BY_RD_I: begin
                    r_i <= w_i_n;
                end
                rc4_pkg::STEP_BY_RD_J: begin
                    r_j <= w_j_n;
                end
                default: begin
                end
            endcase

            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_data <= i_data_byte;
            r_eom  <= i_end_of_message;
        end
        if ((i_cmd.step == rc4_pkg::STEP_KS_RD_ACC) ||
            (i_cmd.step == rc4_pkg::STEP_BY_RD_J)) begin
            r_sk <= r_rd;
        end
        if (i_cmd.step == rc4_pkg::STEP_BY_WR_I) begin
            r_sj    <= r_rd;
            r_fwd_i <= (w_t == r_i);
            r_fwd_j <= (w_t == r_j);
        end
        if (w_load_out) begin
            r_out_byte <= r_data ^ w_ks;
            r_out_eom  <= r_eom;
            r_out_nk   <= !r_keyed;
        end
    end

    assign o_status.keyed    = r_keyed;
    assign o_status.k_last   = (r_k == '1);
    assign o_status.out_free = w_out_free;

    assign o_out_valid          = r_out_valid;
    assign o_out_byte           = r_out_byte;
    assign o_end_of_message_out = r_out_eom;
    assign o_not_keyed          = r_out_nk;

    `RC4_ASSERT_NEXT(a_schedule_sets_keyed, i_clk, i_rst_n,
        (i_cmd.step == rc4_pkg::STEP_KS_WR_ACC) && (r_k == '1),
        r_keyed && (r_i == '0) && (r_j == '0),
        "key schedule end did not arm the generator")
    `RC4_ASSERT_NEXT(a_out_loaded, i_clk, i_rst_n, w_load_out, r_out_valid,
        "result not presented after load")
    `RC4_ASSERT_HOLDS(a_kidx_in_range, i_clk, i_rst_n,
        (i_cmd.step == rc4_pkg::STEP_KS_RD_ACC) |-> (r_kidx <= w_last_kidx),
        "key byte index beyond key length")

endmodule

// ===== src/rc4_stream_cipher.sv =====
// Top level of the RC4 stream cipher: controller, datapath and channel wiring
//
//  channel   | direction | handshake           | carries
//  ----------+-----------+---------------------+--------------------------------------
//  i_req     | in        | valid/ready         | req_type, data_byte, end_of_message
//  o_rsp     | out       | valid/ready         | out_byte, end_of_message_out, not_keyed
//  i_cfg_*   | in        | write enable only   | register index, 64-bit write data
//
//  A key schedule request fills the S-box with the identity, then makes 256 swaps, each
//  as read S[k], read S[acc], write S[k], write S[acc]. A keyed data byte reads S[i],
//  reads S[j], writes S[i] while reading S[S[i]+S[j]], writes S[j], then outputs; an
//  unkeyed one goes straight to output; the S-box has one read and one write port.
//  Reset (synchronous) clears indices, keyed flag and key words, sets key length to 16;
//  the S-box is not cleared and holds garbage until the first key schedule writes it.
//  A finished byte waits in the output register while new requests are taken; the
//  next byte holds in its output step until that transaction completes, and no new
//  request is taken meanwhile.
module rc4_stream_cipher #(
    parameter int MAX_KEY_BYTES = rc4_pkg::DEFAULT_MAX_KEY_BYTES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rc4_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [rc4_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    rc4_req_if.sink                        i_req,
    rc4_rsp_if.source                      o_rsp
);

    rc4_pkg::t_dp_cmd    w_cmd;
    rc4_pkg::t_dp_status w_status;

    // Sequence the fill, the swaps and the per-byte steps
    rc4_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_req_type (i_req.req_type),
        .o_in_ready (i_req.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Hold the key, the permutation, both indices and the result register
    rc4_dp #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_addr           (i_cfg_addr),
        .i_cfg_wdata          (i_cfg_wdata),
        .i_cmd                (w_cmd),
        .o_status             (w_status),
        .i_data_byte          (i_req.data_byte),
        .i_end_of_message     (i_req.end_of_message),
        .i_out_ready          (o_rsp.ready),
        .o_out_valid          (o_rsp.valid),
        .o_out_byte           (o_rsp.out_byte),
        .o_end_of_message_out (o_rsp.end_of_message_out),
        .o_not_keyed          (o_rsp.not_keyed)
    );

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the RC4 stream cipher: directed table, then random messages
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BYTE_W        = rc4_pkg::BYTE_W;
    localparam int CFG_ADDR_W    = rc4_pkg::CFG_ADDR_W;
    localparam int CFG_DATA_W    = rc4_pkg::CFG_DATA_W;
    localparam int LEN_W         = rc4_pkg::LEN_W;
    localparam int SBOX_DEPTH    = rc4_pkg::SBOX_DEPTH;
    localparam int KEY_WORDS     = rc4_pkg::KEY_WORDS;

    localparam int CLK_PERIOD    = 4;
    localparam int RESET_CYCLES  = 8;
    localparam int RANDOM_ITEMS  = 400;
    localparam int MAX_SHOWN     = 10;
    // Wait bound for a key schedule from acceptance back to idle, padded.
    localparam int SCHED_CYCLES  = 1320;
    localparam int END_WAIT      = 4000;
    localparam int KEY_BYTES_MAX = rc4_pkg::DEFAULT_MAX_KEY_BYTES;

    // Indexes past the register list; writes there must be dropped.
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_FIRST =
        rc4_pkg::CFG_KEY_LENGTH + CFG_ADDR_W'(1);

    typedef struct {
        logic [BYTE_W-1:0] byte_val;
        logic              eom;
        logic              nk;
    } t_cipher_out;

    typedef enum logic {ROW_CFG, ROW_REQ} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic [CFG_ADDR_W-1:0] addr;
        logic [CFG_DATA_W-1:0] wdata;
        logic                  req_type;
        logic [BYTE_W-1:0]     data;
        logic                  eom;
        bit                    known;
        logic [BYTE_W-1:0]     want_byte;
        logic                  want_nk;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    rc4_req_if req_ch ();
    rc4_rsp_if rsp_ch ();

    rc4_stream_cipher i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Cipher state as the block should hold it, plus its register copy
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0]     sbox_model [SBOX_DEPTH];
    logic [BYTE_W-1:0]     ptr_i;
    logic [BYTE_W-1:0]     ptr_j;
    logic                  model_keyed;
    logic [CFG_DATA_W-1:0] key_reg [KEY_WORDS];
    logic [LEN_W-1:0]      key_len_reg;

    t_cipher_out pending_outputs [$];
    int          err_cnt         = 0;
    int          sent_cnt        = 0;
    int          cycle_cnt       = 0;
    int          last_sched_cyc  = -SCHED_CYCLES;
    bit          calm            = 0;

    always @(posedge i_clk) cycle_cnt <= cycle_cnt + 1;

    // Rebuild the permutation from the key registers; length 0 acts as 1,
    // anything past the maximum saturates.
    function automatic void rekey_model();
        int unsigned       n;
        int unsigned       kidx;
        logic [BYTE_W-1:0] acc;
        logic [BYTE_W-1:0] kb;
        logic [BYTE_W-1:0] t;
        n = 32'(key_len_reg);
        if (n == 0) n = 1;
        if (n > KEY_BYTES_MAX) n = KEY_BYTES_MAX;
        for (int k = 0; k < SBOX_DEPTH; k++) sbox_model[BYTE_W'(k)] = BYTE_W'(k);
        acc = '0;
        for (int k = 0; k < SBOX_DEPTH; k++) begin
            kidx = k % n;
            kb   = BYTE_W'(key_reg[2'(kidx >> 3)] >> (8 * (kidx & 7)));
            acc  = acc + sbox_model[BYTE_W'(k)] + kb;
            t                         = sbox_model[BYTE_W'(k)];
            sbox_model[BYTE_W'(k)]    = sbox_model[acc];
            sbox_model[acc]           = t;
        end
        ptr_i       = '0;
        ptr_j       = '0;
        model_keyed = 1'b1;
    endfunction

    // One generator step; an unkeyed byte passes straight through.
    function automatic t_cipher_out cipher_byte(logic [BYTE_W-1:0] d, logic e);
        t_cipher_out       r;
        logic [BYTE_W-1:0] t;
        r.eom = e;
        if (!model_keyed) begin
            r.byte_val = d;
            r.nk       = 1'b1;
            return r;
        end
        ptr_i             = ptr_i + BYTE_W'(1);
        ptr_j             = ptr_j + sbox_model[ptr_i];
        t                 = sbox_model[ptr_i];
        sbox_model[ptr_i] = sbox_model[ptr_j];
        sbox_model[ptr_j] = t;
        r.byte_val = d ^ sbox_model[BYTE_W'(sbox_model[ptr_i] + sbox_model[ptr_j])];
        r.nk       = 1'b0;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Mostly back-to-back, sometimes a few cycles, rarely a long pause.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_key_word();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Drive one register write; the write lands at the next edge. The enable
    // is dropped by whatever comes next, so back-to-back writes stay high.
    task automatic cfg_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] wdata);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= wdata;
        @(posedge i_clk);
        case (addr)
            rc4_pkg::CFG_KEY_WORD_0, rc4_pkg::CFG_KEY_WORD_1,
            rc4_pkg::CFG_KEY_WORD_2, rc4_pkg::CFG_KEY_WORD_3: key_reg[addr[1:0]] = wdata;
            rc4_pkg::CFG_KEY_LENGTH: key_len_reg = wdata[LEN_W-1:0];
            default: ;
        endcase
    endtask

    // Offer one request and hold it until the transaction completes. The
    // model advances at the accepting edge, so expectations stay in order.
    task automatic send_req(logic rtype, logic [BYTE_W-1:0] d, logic e,
                            bit known = 0, logic [BYTE_W-1:0] want_b = '0,
                            logic want_nk = 1'b0);
        int unsigned gap;
        t_cipher_out res;
        gap = pick_gap();
        i_cfg_we <= 1'b0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.req_type       <= rtype;
        req_ch.data_byte      <= d;
        req_ch.end_of_message <= e;
        do @(posedge i_clk); while (!(req_ch.valid && req_ch.ready));
        sent_cnt++;
        if (rtype == rc4_pkg::REQ_KEY_SCHEDULE) begin
            rekey_model();
            last_sched_cyc = cycle_cnt;
        end else begin
            res = cipher_byte(d, e);
            if (known) begin
                res.byte_val = want_b;
                res.nk       = want_nk;
            end
            pending_outputs.push_back(res);
        end
    endtask

    // Wait until the block is idle: every result back and any key schedule done.
    task automatic settle();
        req_ch.valid <= 1'b0;
        i_cfg_we     <= 1'b0;
        do @(posedge i_clk);
        while (pending_outputs.size() != 0 || cycle_cnt < last_sched_cyc + SCHED_CYCLES);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic note_mismatch(string what, int unsigned want, int unsigned got);
        err_cnt++;
        if (err_cnt <= MAX_SHOWN)
            $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure and the field-by-field compare
    // ------------------------------------------------------------------
    initial begin
        int unsigned stall;
        int unsigned burst;
        rsp_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            burst = $urandom_range(1, 16);
            repeat (burst) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_cipher_out want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_outputs.size() == 0) begin
                note_mismatch("unexpected result byte", 0, 32'(rsp_ch.out_byte));
            end else begin
                want = pending_outputs.pop_front();
                if (rsp_ch.out_byte !== want.byte_val)
                    note_mismatch("out_byte", 32'(want.byte_val), 32'(rsp_ch.out_byte));
                if (rsp_ch.end_of_message_out !== want.eom)
                    note_mismatch("end_of_message_out", 32'(want.eom),
                                  32'(rsp_ch.end_of_message_out));
                if (rsp_ch.not_keyed !== want.nk)
                    note_mismatch("not_keyed", 32'(want.nk), 32'(rsp_ch.not_keyed));
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    function automatic t_dir_row cfg_row(logic [CFG_ADDR_W-1:0] a, logic [CFG_DATA_W-1:0] d);
        t_dir_row r;
        r.kind      = ROW_CFG;
        r.addr      = a;
        r.wdata     = d;
        r.req_type  = rc4_pkg::REQ_DATA;
        r.data      = '0;
        r.eom       = 1'b0;
        r.known     = 1'b0;
        r.want_byte = '0;
        r.want_nk   = 1'b0;
        return r;
    endfunction

    function automatic t_dir_row req_row(logic t, logic [BYTE_W-1:0] d, logic e);
        t_dir_row r;
        r.kind      = ROW_REQ;
        r.addr      = '0;
        r.wdata     = '0;
        r.req_type  = t;
        r.data      = d;
        r.eom       = e;
        r.known     = 1'b0;
        r.want_byte = '0;
        r.want_nk   = 1'b0;
        return r;
    endfunction

    // Data row whose result is fixed in advance.
    function automatic t_dir_row known_row(logic [BYTE_W-1:0] d, logic e,
                                           logic [BYTE_W-1:0] wb, logic wnk);
        t_dir_row r;
        r           = req_row(rc4_pkg::REQ_DATA, d, e);
        r.known     = 1'b1;
        r.want_byte = wb;
        r.want_nk   = wnk;
        return r;
    endfunction

    t_dir_row dir_rows [$];

    initial begin
        // Before any key schedule: bytes pass through, flagged not keyed.
        dir_rows.push_back(known_row(8'h00, 1'b0, 8'h00, 1'b1));
        dir_rows.push_back(known_row(8'hFF, 1'b1, 8'hFF, 1'b1));
        dir_rows.push_back(known_row(8'hA5, 1'b0, 8'hA5, 1'b1));
        // Textbook vector: key "Key", plaintext "Plaintext".
        dir_rows.push_back(cfg_row(rc4_pkg::CFG_KEY_WORD_0, 64'h0000_0000_0079_654B));
        dir_rows.push_back(cfg_row(rc4_pkg::CFG_KEY_LENGTH, 64'd3));
        dir_rows.push_back(req_row(rc4_pkg::REQ_KEY_SCHEDULE, 8'h00, 1'b0));
        dir_rows.push_back(req_row(rc4_pkg::REQ_DATA, 8'h50, 1'b0));
        dir_rows.push_back(req_row(rc4_pkg::REQ_DATA, 8'h6C, 1'b0));
        dir_rows.push_back(req_row(rc4_pkg::REQ_DATA, 8'h61, 1'b0));
        dir_rows.push_back(req_row(rc4_pkg::REQ_DATA, 8'h69, 1'b0));
        dir_rows.push_back(req_row(rc4_pkg::REQ_DATA, 8'h6E, 1'b0));
        dir_rows.push_back(req_row(rc4_pkg::REQ_DATA, 8'h74, 1'b0));
        dir_rows.push_back(req_row(rc4_pkg::REQ_DATA, 8'h65, 1'b0));
        dir_rows.push_back(req_row(rc4_pkg::REQ_DATA, 8'h78, 1'b0));
        dir_rows.push_back(req_row(rc4_pkg::REQ_DATA, 8'h74, 1'b1));
        // Key length zero behaves as a single key byte.
        dir_rows.push_back(cfg_row(rc4_pkg::CFG_KEY_WORD_0, '1));
        dir_rows.push_back(cfg_row(rc4_pkg::CFG_KEY_LENGTH, 64'd0));
        dir_rows.push_back(req_row(rc4_pkg::REQ_KEY_SCHEDULE, 8'hFF, 1'b1));
        dir_rows.push_back(req_row(rc4_pkg::REQ_DATA, 8'h00, 1'b0));
        dir_rows.push_back(req_row(rc4_pkg::REQ_DATA, 8'hFF, 1'b1));
        // Oversized length saturates; spare indexes must not disturb anything;
        // a second key schedule rekeys from scratch.
        dir_rows.push_back(cfg_row(rc4_pkg::CFG_KEY_WORD_0, 64'h0123_4567_89AB_CDEF));
        dir_rows.push_back(cfg_row(rc4_pkg::CFG_KEY_WORD_1, 64'hFEDC_BA98_7654_3210));
        dir_rows.push_back(cfg_row(rc4_pkg::CFG_KEY_WORD_2, 64'hFFFF_FFFF_0000_0000));
        dir_rows.push_back(cfg_row(rc4_pkg::CFG_KEY_WORD_3, 64'h8000_0000_0000_0001));
        dir_rows.push_back(cfg_row(rc4_pkg::CFG_KEY_LENGTH, 64'd63));
        dir_rows.push_back(cfg_row(CFG_SPARE_FIRST, '1));
        dir_rows.push_back(cfg_row(CFG_SPARE_FIRST + CFG_ADDR_W'(1), '1));
        dir_rows.push_back(cfg_row(CFG_SPARE_FIRST + CFG_ADDR_W'(2), '1));
        dir_rows.push_back(req_row(rc4_pkg::REQ_KEY_SCHEDULE, 8'h00, 1'b0));
        dir_rows.push_back(req_row(rc4_pkg::REQ_KEY_SCHEDULE, 8'h00, 1'b0));
        dir_rows.push_back(req_row(rc4_pkg::REQ_DATA, 8'h5A, 1'b0));
        dir_rows.push_back(req_row(rc4_pkg::REQ_DATA, 8'h00, 1'b1));
        // Full-length key, and one just past the limit.
        dir_rows.push_back(cfg_row(rc4_pkg::CFG_KEY_LENGTH, 64'd32));
        dir_rows.push_back(req_row(rc4_pkg::REQ_KEY_SCHEDULE, 8'h00, 1'b0));
        dir_rows.push_back(req_row(rc4_pkg::REQ_DATA, 8'h3C, 1'b1));
        dir_rows.push_back(cfg_row(rc4_pkg::CFG_KEY_LENGTH, 64'd33));
        dir_rows.push_back(req_row(rc4_pkg::REQ_KEY_SCHEDULE, 8'h00, 1'b0));
        dir_rows.push_back(req_row(rc4_pkg::REQ_DATA, 8'hC3, 1'b1));
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned msg_len;
        logic        eom;
        bit          prev_cfg;

        // Register copy starts at the reset values.
        key_reg     = '{default: '0};
        key_len_reg = rc4_pkg::KEY_LENGTH_RESET;
        ptr_i       = '0;
        ptr_j       = '0;
        model_keyed = 1'b0;

        i_rst_n               <= 1'b0;
        i_cfg_we              <= 1'b0;
        i_cfg_addr            <= '0;
        i_cfg_wdata           <= '0;
        req_ch.valid          <= 1'b0;
        req_ch.req_type       <= rc4_pkg::REQ_DATA;
        req_ch.data_byte      <= '0;
        req_ch.end_of_message <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table; settle before each batch of register writes.
        prev_cfg = 0;
        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                if (!prev_cfg) settle();
                cfg_write(dir_rows[r].addr, dir_rows[r].wdata);
                prev_cfg = 1;
            end else begin
                send_req(dir_rows[r].req_type, dir_rows[r].data, dir_rows[r].eom,
                         dir_rows[r].known, dir_rows[r].want_byte, dir_rows[r].want_nk);
                prev_cfg = 0;
            end
        end

        // Random phases: new key material, a rekey, then one message. A few
        // phases skip the rekey, rekey in mid-message or mark ends at random.
        sent_cnt = 0;
        while (sent_cnt < RANDOM_ITEMS) begin
            settle();
            calm = ($urandom_range(0, 4) == 0);
            for (int w = 0; w < KEY_WORDS; w++)
                if ($urandom_range(0, 1) == 1)
                    cfg_write(rc4_pkg::CFG_KEY_WORD_0 + w[CFG_ADDR_W-1:0], pick_key_word());
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 7))
                    0:       cfg_write(rc4_pkg::CFG_KEY_LENGTH, 64'd1);
                    1:       cfg_write(rc4_pkg::CFG_KEY_LENGTH, 64'd32);
                    2:       cfg_write(rc4_pkg::CFG_KEY_LENGTH, 64'd0);
                    3:       cfg_write(rc4_pkg::CFG_KEY_LENGTH, 64'($urandom_range(33, 63)));
                    default: cfg_write(rc4_pkg::CFG_KEY_LENGTH, 64'($urandom_range(1, 32)));
                endcase
            end
            if ($urandom_range(0, 9) == 0)
                cfg_write(CFG_SPARE_FIRST + CFG_ADDR_W'($urandom_range(0, 2)),
                          {$urandom, $urandom});

            if ($urandom_range(0, 9) != 0)
                send_req(rc4_pkg::REQ_KEY_SCHEDULE, 8'($urandom), 1'($urandom));

            msg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 80)
                                                  : $urandom_range(1, 24);
            for (int k = 0; k < msg_len; k++) begin
                if ($urandom_range(0, 39) == 0)
                    send_req(rc4_pkg::REQ_KEY_SCHEDULE, 8'($urandom), 1'($urandom));
                eom = (k == msg_len - 1) || ($urandom_range(0, 19) == 0);
                send_req(rc4_pkg::REQ_DATA, 8'($urandom_range(0, 255)), eom);
            end
        end
        calm = 0;

        // Drain: give the last results a bounded time to come back.
        req_ch.valid <= 1'b0;
        i_cfg_we     <= 1'b0;
        for (int w = 0; w < END_WAIT && pending_outputs.size() != 0; w++)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (pending_outputs.size() != 0) begin
            err_cnt++;
            $display("%0d expected result bytes never arrived", pending_outputs.size());
        end

        if (err_cnt == 0)
            $display("rc4_stream_cipher regression: pass");
        else
            $display("rc4_stream_cipher regression: fail");
        $finish;
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #10_000_000;
        $display("rc4_stream_cipher regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/rc4_pkg.sv
src/rc4_req_if.sv
src/rc4_rsp_if.sv
src/rc4_ctrl.sv
src/rc4_dp.sv
src/rc4_stream_cipher.sv
bench/tb.sv
